>>> rtl/core/fixed_key_value_table_core_defines.svh
// assertion macros for the fixed key/value table core
// no dependencies; included by the files that carry assertions
`ifndef FIXED_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define FIXED_KEY_VALUE_TABLE_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FKVT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fkvt assertion failed");

// next-cycle implication, disabled while in reset
`define FKVT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fkvt assertion failed");

`endif

>>> rtl/core/fkvt_pkg.sv
// shared types, constants and the string trim function of the key/value table
// no dependencies
package fkvt_pkg;

  localparam int DEF_ENTRIES     = 16;
  localparam int DEF_KEY_BYTES   = 8;
  localparam int DEF_VALUE_BYTES = 8;

  localparam int WORD_W      = 64;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY_KEY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // keep bytes up to the first zero byte, at most nbytes of them
  function automatic logic [WORD_W-1:0] trim_word(logic [WORD_W-1:0] w,
                                                  int unsigned nbytes);
    logic [WORD_W-1:0] r;
    logic              run;
    r   = '0;
    run = 1'b1;
    for (int unsigned i = 0; i < WORD_W / 8; i++) begin
      if (i >= nbytes || w[8*i +: 8] == 8'h00) begin
        run = 1'b0;
      end
      if (run) begin
        r[8*i +: 8] = w[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/fkvt_slot_ram.sv
// slot memory of the key/value table: one write port, one registered read port
// depends on nothing but its parameters
module fkvt_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/fixed_key_value_table_core.sv
// top level of the fixed-capacity key/value table
// depends on fkvt_pkg, fkvt_slot_ram and fixed_key_value_table_core_defines.svh
//
//  channel | direction | tdata (low bit up)                 | tuser
//  in_     | request   | key_word[63:0], value_word[127:64] | kind[1:0]
//  out_    | result    | found_value[63:0], live_count[68:64] | status[1:0]
//
// set, get and remove scan the key memory one slot a cycle; a hit ends the scan,
// while clear and a set with an empty key skip the scan and go straight to the result.
// reset clears the valid bits and the live count at once, no clearing pass.
// a result waits in the output register; the next request is taken meanwhile but
// its own result holds until the output register frees.
`include "fixed_key_value_table_core_defines.svh"

module fixed_key_value_table_core
  import fkvt_pkg::*;
#(
  parameter int ENTRIES     = DEF_ENTRIES,
  parameter int KEY_BYTES   = DEF_KEY_BYTES,
  parameter int VALUE_BYTES = DEF_VALUE_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // key_word[63:0], value_word[127:64]
  input  logic [1:0]             in_tuser,   // kind[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // found_value[63:0], live_count[68:64]
  output logic [1:0]             out_tuser   // status[1:0]
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  state_t            state_r, state_nxt;
  kind_t             kind_r, kind_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     iss_r, iss_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IW-1:0]     free_idx_r, free_idx_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              take_val_r, take_val_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic              in_fire;
  logic              out_load;
  logic              inst_en;
  logic [IW-1:0]     free_sel;
  logic              hit;
  logic              last_cmp;
  logic [WORD_W-1:0] in_key_trim;
  logic [WORD_W-1:0] in_val_trim;

  logic              key_we, key_re;
  logic [IW-1:0]     key_raddr;
  logic [WORD_W-1:0] key_q;
  logic              val_we, val_re;
  logic [IW-1:0]     val_waddr;
  logic [WORD_W-1:0] val_q;

  fkvt_slot_ram #(.DEPTH(ENTRIES), .WIDTH(WORD_W)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (free_sel),
    .wdata (key_r),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_q)
  );

  fkvt_slot_ram #(.DEPTH(ENTRIES), .WIDTH(WORD_W)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_r),
    .re    (val_re),
    .raddr (cmp_idx_r),
    .rdata (val_q)
  );

  assign in_tready   = (state_r == S_IDLE);
  assign in_fire     = in_tvalid && in_tready;
  assign in_key_trim = trim_word(in_tdata[WORD_W-1:0], KEY_BYTES);
  assign in_val_trim = trim_word(in_tdata[2*WORD_W-1:WORD_W], VALUE_BYTES);

  assign hit      = cmp_vld_r && valid_r[cmp_idx_r] && (key_q == key_r);
  assign last_cmp = cmp_vld_r && (cmp_idx_r == IW'(ENTRIES - 1));
  assign free_sel = free_found_r ? free_idx_r : cmp_idx_r;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_TDATA_W - WORD_W - COUNT_W){1'b0}}, out_count_r, out_value_r};

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    iss_nxt        = iss_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_status_nxt = res_status_r;
    take_val_nxt   = take_val_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    key_we         = 1'b0;
    key_re         = 1'b0;
    key_raddr      = iss_r[IW-1:0];
    val_we         = 1'b0;
    val_re         = 1'b0;
    val_waddr      = cmp_idx_r;
    inst_en        = 1'b0;
    out_load       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt       = kind_t'(in_tuser);
          key_nxt        = in_key_trim;
          val_nxt        = in_val_trim;
          iss_nxt        = '0;
          free_found_nxt = 1'b0;
          take_val_nxt   = 1'b0;
          res_status_nxt = ST_OK;
          if (kind_t'(in_tuser) == KIND_CLEAR) begin
            valid_nxt = '0;
            count_nxt = '0;
            state_nxt = S_DONE;
          end else if (kind_t'(in_tuser) == KIND_SET && in_key_trim == '0) begin
            res_status_nxt = ST_EMPTY_KEY;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read slot iss_r now, compare it in the following cycle
        if (iss_r < CW'(ENTRIES)) begin
          key_re      = 1'b1;
          iss_nxt     = iss_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = iss_r[IW-1:0];
        end
        if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = cmp_idx_r;
        end
        if (hit) begin
          state_nxt      = S_DONE;
          res_status_nxt = ST_OK;
          unique case (kind_r)
            KIND_SET: begin
              val_we = 1'b1;
            end
            KIND_GET: begin
              val_re       = 1'b1;
              take_val_nxt = 1'b1;
            end
            KIND_REMOVE: begin
              valid_nxt[cmp_idx_r] = 1'b0;
              count_nxt            = count_r - CW'(1);
            end
            KIND_CLEAR: begin
            end
          endcase
        end else if (last_cmp) begin
          state_nxt = S_DONE;
          if (kind_r == KIND_SET) begin
            if (count_r >= CW'(ENTRIES)) begin
              res_status_nxt = ST_FULL;
            end else begin
              // a free slot must exist when the count is below capacity
              inst_en             = 1'b1;
              key_we              = 1'b1;
              val_we              = 1'b1;
              val_waddr           = free_sel;
              valid_nxt[free_sel] = 1'b1;
              count_nxt           = count_r + CW'(1);
              res_status_nxt      = ST_OK;
            end
          end else begin
            res_status_nxt = ST_NOT_FOUND;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load       = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = take_val_r ? val_q : '0;
          out_count_nxt  = COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      iss_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      iss_r       <= iss_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    take_val_r   <= take_val_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  `FKVT_ASSERT_IMP(a_count_matches_valid, 1'b1, $countones(valid_r) == count_r)
  `FKVT_ASSERT_IMP(a_install_into_free_slot, inst_en, !valid_r[free_sel])
  `FKVT_ASSERT_IMP(a_full_only_at_capacity, out_load && res_status_r == ST_FULL,
                   count_r == CW'(ENTRIES))
  `FKVT_ASSERT_NXT(a_get_hit_returns_value, hit && kind_r == KIND_GET,
                   state_r == S_DONE && take_val_r)

endmodule

>>> verif/tb_top.sv
// self-checking testbench for fixed_key_value_table_core: a table predictor checks every reply
// depends on fkvt_pkg and the rtl of fixed_key_value_table_core
module tb_top
  import fkvt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = DEF_ENTRIES;
  localparam int KEY_LEN      = DEF_KEY_BYTES;
  localparam int VAL_LEN      = DEF_VALUE_BYTES;
  localparam int POOL_SIZE    = 24;
  localparam int RANDOM_OPS   = 1900;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
  } table_request_t;

  typedef struct packed {
    status_t            status;
    logic [WORD_W-1:0]  value;
    logic [COUNT_W-1:0] count;
  } table_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [1:0]             in_tuser   = KIND_SET;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  fixed_key_value_table_core #(
    .ENTRIES    (SLOTS),
    .KEY_BYTES  (KEY_LEN),
    .VALUE_BYTES(VAL_LEN)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the table
  logic [WORD_W-1:0] shadow_key[SLOTS];
  logic [WORD_W-1:0] shadow_val[SLOTS];
  bit                shadow_used[SLOTS];
  int                shadow_total = 0;

  table_request_t ops_to_send[$];
  table_result_t  predicted_replies[$];
  table_result_t  want;
  int             err_count    = 0;
  int             cycle_count  = 0;
  logic           req_accepted = 1'b0;

  function automatic logic [WORD_W-1:0] cut_string(logic [WORD_W-1:0] w, int nbytes);
    logic [WORD_W-1:0] r;
    int                i;
    r = '0;
    for (i = 0; i < WORD_W / 8; i++) begin
      if (i >= nbytes || w[8*i +: 8] == 8'h00) break;
      r[8*i +: 8] = w[8*i +: 8];
    end
    return r;
  endfunction

  function automatic table_result_t apply_table_op(table_request_t rq);
    table_result_t     res;
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] v;
    int                hit;
    int                i;
    k          = cut_string(rq.key, KEY_LEN);
    v          = cut_string(rq.value, VAL_LEN);
    res.status = ST_OK;
    res.value  = '0;
    hit        = -1;
    for (i = 0; i < SLOTS; i++) begin
      if (hit < 0 && shadow_used[i] && shadow_key[i] == k) hit = i;
    end
    case (rq.kind)
      KIND_SET: begin
        if (k == '0) begin
          res.status = ST_EMPTY_KEY;
        end else if (hit >= 0) begin
          shadow_val[hit] = v;
        end else if (shadow_total >= SLOTS) begin
          res.status = ST_FULL;
        end else begin
          for (i = 0; i < SLOTS; i++) begin
            if (!shadow_used[i]) begin
              shadow_key[i]  = k;
              shadow_val[i]  = v;
              shadow_used[i] = 1'b1;
              shadow_total++;
              break;
            end
          end
        end
      end
      KIND_GET: begin
        if (hit >= 0) res.value = shadow_val[hit];
        else res.status = ST_NOT_FOUND;
      end
      KIND_REMOVE: begin
        if (hit >= 0) begin
          shadow_used[hit] = 1'b0;
          if (shadow_total > 0) shadow_total--;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        for (i = 0; i < SLOTS; i++) shadow_used[i] = 1'b0;
        shadow_total = 0;
      end
    endcase
    res.count = COUNT_W'(shadow_total);
    return res;
  endfunction

  function automatic void queue_op(kind_t kind, logic [WORD_W-1:0] key,
                                   logic [WORD_W-1:0] value);
    table_request_t rq;
    rq.kind  = kind;
    rq.key   = key;
    rq.value = value;
    ops_to_send.push_back(rq);
  endfunction

  // request driver: bursts with random gaps, inputs change on the falling edge
  int burst_left = 1;
  int gap_left   = 0;
  int pick;

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || req_accepted)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (ops_to_send.size() > 0) begin
        in_tdata  <= {ops_to_send[0].value, ops_to_send[0].key};
        in_tuser  <= ops_to_send[0].kind;
        in_tvalid <= 1'b1;
        void'(ops_to_send.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          pick       = $urandom_range(0, 99);
          if (pick < 40) gap_left = 0;
          else if (pick < 80) gap_left = $urandom_range(1, 4);
          else gap_left = $urandom_range(5, 25);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // reply side backpressure, switching between several stall patterns
  int rx_mode    = 0;
  int mode_left  = 0;
  int stall_left = 0;
  int rx_phase   = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    rx_phase++;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (rx_phase % 4) != 3;
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(4, 30);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // reply check first, then the prediction for a request taken at this edge
  always @(posedge clk) begin
    req_accepted <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid === 1'b1 && out_tready) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t unexpected reply: status %0d value %h count %0d", $time,
                   out_tuser, out_tdata[WORD_W-1:0], out_tdata[WORD_W +: COUNT_W]);
          err_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_tuser !== want.status) begin
            $display("%0t status mismatch: expected %0d actual %0d", $time,
                     want.status, out_tuser);
            err_count++;
          end
          if (out_tdata[WORD_W-1:0] !== want.value) begin
            $display("%0t found_value mismatch: expected %h actual %h", $time,
                     want.value, out_tdata[WORD_W-1:0]);
            err_count++;
          end
          if (out_tdata[WORD_W +: COUNT_W] !== want.count) begin
            $display("%0t live_count mismatch: expected %0d actual %0d", $time,
                     want.count, out_tdata[WORD_W +: COUNT_W]);
            err_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predicted_replies.push_back(apply_table_op(table_request_t'{
          kind: kind_t'(in_tuser), key: in_tdata[WORD_W-1:0],
          value: in_tdata[IN_TDATA_W-1:WORD_W]}));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL fixed_key_value_table_core");
      $finish;
    end
  end

  logic [WORD_W-1:0] key_pool[POOL_SIZE];
  int                key_pool_len[POOL_SIZE];
  logic [WORD_W-1:0] key_w;
  logic [WORD_W-1:0] val_w;
  int                mix_mode;
  int                mix_left;
  int                idx;
  int                len;
  int                r;
  kind_t             op_kind;

  initial begin
    for (int i = 0; i < SLOTS; i++) shadow_used[i] = 1'b0;

    // directed: misses on an empty table
    queue_op(KIND_GET,    64'h0000_0000_0000_0031, '0);
    queue_op(KIND_REMOVE, 64'h0000_0000_0000_0031, '0);
    // empty key with junk behind the terminator
    queue_op(KIND_SET,    64'h1122_3344_5566_7700, 64'h0000_0000_0000_0042);
    queue_op(KIND_GET,    64'h1122_3344_5566_7700, '0);
    // full-width key and value, overwrite with a null value
    queue_op(KIND_SET,    '1, '1);
    queue_op(KIND_SET,    '1, '0);
    queue_op(KIND_GET,    '1, '0);
    // bytes after the first zero byte are ignored
    queue_op(KIND_SET,    64'h5a3c_e1f0_9d17_0041, 64'hffee_ddcc_bb00_1234);
    queue_op(KIND_GET,    64'hc3b2_a190_8877_0041, '0);
    // fill the remaining slots, then overflow
    for (int i = 0; i < SLOTS - 2; i++) begin
      queue_op(KIND_SET, 64'h0000_0000_0000_7430 + i, 64'h0000_0000_0000_0100 + i);
    end
    queue_op(KIND_SET,    64'h0000_0000_0077_6f6e, 64'h0000_0000_0000_0001);
    queue_op(KIND_REMOVE, 64'h0000_0000_0000_0041, '0);
    queue_op(KIND_CLEAR,  '0, '0);

    // key pool larger than the table so that full and hits both happen
    for (int p = 0; p < POOL_SIZE; p++) begin
      key_pool_len[p] = $urandom_range(1, KEY_LEN);
      key_pool[p]     = '0;
      for (int b = 0; b < key_pool_len[p]; b++) key_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
    end

    mix_mode = 0;
    mix_left = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (mix_left == 0) begin
        mix_mode = $urandom_range(0, 2);
        mix_left = $urandom_range(20, 60);
      end
      mix_left--;
      r = $urandom_range(0, 99);
      case (mix_mode)
        0: op_kind = r < 70 ? KIND_SET : r < 85 ? KIND_GET : r < 99 ? KIND_REMOVE : KIND_CLEAR;
        1: op_kind = r < 40 ? KIND_SET : r < 70 ? KIND_GET : r < 97 ? KIND_REMOVE : KIND_CLEAR;
        default:
          op_kind = r < 15 ? KIND_SET : r < 40 ? KIND_GET : r < 98 ? KIND_REMOVE : KIND_CLEAR;
      endcase

      r = $urandom_range(0, 99);
      if (r < 85) begin
        idx   = $urandom_range(0, POOL_SIZE - 1);
        key_w = key_pool[idx];
        // junk above the terminator of a short key
        if (key_pool_len[idx] < KEY_LEN && $urandom_range(0, 2) == 0) begin
          for (int b = key_pool_len[idx] + 1; b < WORD_W / 8; b++) key_w[8*b +: 8] = 8'($urandom);
        end
      end else if (r < 93) begin
        key_w = {$urandom, $urandom};
      end else begin
        key_w       = {$urandom, $urandom};
        key_w[7:0]  = 8'h00;
      end

      r = $urandom_range(0, 99);
      if (r < 10) begin
        val_w = '0;
      end else if (r < 30) begin
        val_w = {$urandom, $urandom};
        len   = $urandom_range(0, VAL_LEN - 1);
        val_w[8*len +: 8] = 8'h00;
      end else begin
        val_w = {$urandom, $urandom};
      end
      queue_op(op_kind, key_w, val_w);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // checked at the rising edge, after the driver's updates have settled
    forever begin
      @(posedge clk);
      if (ops_to_send.size() == 0 && !in_tvalid && predicted_replies.size() == 0) break;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0 && predicted_replies.size() == 0) begin
      $display("PASS fixed_key_value_table_core");
    end else begin
      $display("FAIL fixed_key_value_table_core");
    end
    $finish;
  end

endmodule
